[sv/gbn_pkg.sv]
// Shared types and constants for the go-back-n sender.
// Used by the controller, datapath, top level and checker.
package gbn_pkg;

    localparam int MAX_FRAMES  = 32;
    localparam int SEQ_MODULUS = 8;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(MAX_FRAMES);
    localparam int IDX_W   = $clog2(MAX_FRAMES + 1);
    localparam int SEQ_W   = $clog2(SEQ_MODULUS);
    localparam int WIN_W   = 3;
    localparam int FC_W    = 6;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(5);
    localparam logic [FC_W-1:0]  COUNT_RESET = FC_W'(20);

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        FN_LOAD    = 2'd0,
        FN_ACK     = 2'd1,
        FN_TIMEOUT = 2'd2,
        FN_START   = 2'd3
    } func_t;

    typedef struct packed {
        logic load;     // store payload of accepted load item
        logic latch;    // capture func and ack of accepted event
        logic eval;     // apply ack slide, plan emission
        logic issue;    // read one frame into the output register
    } gbn_cmd_t;

    typedef struct packed {
        logic eval_empty;   // planned event emits nothing
        logic emit_last;    // frame being issued is the last of the event
        logic out_free;     // output register can take a frame this cycle
    } gbn_status_t;

endpackage

[sv/gbn_ctrl.sv]
// Controller state machine of the go-back-n sender.
// Depends on gbn_pkg; drives commands to gbn_datapath.
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [1:0]  s_func,
    output logic        s_ready,
    input  gbn_status_t status,
    output gbn_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (func_t'(s_func) == FN_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.latch  = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.eval_empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.issue = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/gbn_datapath.sv]
// Datapath of the go-back-n sender: frame store, window pointers,
// config registers and output register. Depends on gbn_pkg.
module gbn_datapath
    import gbn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gbn_cmd_t             cmd,
    output gbn_status_t          status,
    input  logic [1:0]           s_func,
    input  logic [DATA_W-1:0]    s_payload,
    input  logic [SEQ_W-1:0]     s_ack_seq,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SEQ_W-1:0]     m_seq_no,
    output logic [DATA_W-1:0]    m_frame_data,
    output logic                 m_is_resend,
    output logic                 m_last
);

    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_FRAMES);

    logic [DATA_W-1:0] frame_mem [MAX_FRAMES];

    logic [WIN_W-1:0] window_size_reg;
    logic [FC_W-1:0]  frame_count_reg;
    logic [IDX_W-1:0] load_index_reg;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] nts_reg;
    logic [IDX_W-1:0] cursor_reg;
    logic [IDX_W-1:0] rem_res_reg;
    logic [IDX_W-1:0] rem_total_reg;
    func_t            ev_func_reg;
    logic [SEQ_W-1:0] ev_ack_reg;

    logic              out_valid_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_resend_reg;
    logic              out_last_reg;

    logic             slide, do_resend;
    logic [IDX_W-1:0] outst, fc_cap, limit, win_ext;
    logic [IDX_W-1:0] room_win, room_lim, new_cnt, res_cnt, total;

    // event planning
    always_comb begin
        slide = (ev_func_reg == FN_ACK) && (base_reg < nts_reg) &&
                (ev_ack_reg == base_reg[SEQ_W-1:0]);
        do_resend = ((ev_func_reg == FN_ACK) && !slide) || (ev_func_reg == FN_TIMEOUT);
        base_next = base_reg + IDX_W'(slide);
        outst     = nts_reg - base_next;
        fc_cap    = (frame_count_reg > FC_W'(MAX_FRAMES)) ? MAX_IDX : IDX_W'(frame_count_reg);
        limit     = (fc_cap < load_index_reg) ? fc_cap : load_index_reg;
        win_ext   = IDX_W'(window_size_reg);
        room_win  = (win_ext > outst) ? (win_ext - outst) : '0;
        room_lim  = (limit > nts_reg) ? (limit - nts_reg) : '0;
        new_cnt   = (room_win < room_lim) ? room_win : room_lim;
        res_cnt   = do_resend ? outst : '0;
        total     = res_cnt + new_cnt;
    end

    assign status.eval_empty = (total == '0);
    assign status.emit_last  = (rem_total_reg == IDX_W'(1));
    assign status.out_free   = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_RESET;
            frame_count_reg <= COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WINDOW_SIZE: window_size_reg <= cfg_wdata[WIN_W-1:0];
                CFG_FRAME_COUNT: frame_count_reg <= cfg_wdata[FC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && (load_index_reg < MAX_IDX)) begin
            frame_mem[load_index_reg[ADDR_W-1:0]] <= s_payload;
        end
        if (cmd.issue) begin
            rd_data_reg <= frame_mem[cursor_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            ev_func_reg <= func_t'(s_func);
            ev_ack_reg  <= s_ack_seq;
        end
        if (cmd.issue) begin
            out_seq_reg    <= cursor_reg[SEQ_W-1:0];
            out_resend_reg <= (rem_res_reg != '0);
            out_last_reg   <= (rem_total_reg == IDX_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_index_reg <= '0;
            base_reg       <= '0;
            nts_reg        <= '0;
            cursor_reg     <= '0;
            rem_res_reg    <= '0;
            rem_total_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load && (load_index_reg < MAX_IDX)) begin
                load_index_reg <= load_index_reg + IDX_W'(1);
            end
            if (cmd.eval) begin
                base_reg      <= base_next;
                nts_reg       <= nts_reg + new_cnt;
                cursor_reg    <= do_resend ? base_reg : nts_reg;
                rem_res_reg   <= res_cnt;
                rem_total_reg <= total;
            end
            if (cmd.issue) begin
                cursor_reg    <= cursor_reg + IDX_W'(1);
                rem_total_reg <= rem_total_reg - IDX_W'(1);
                if (rem_res_reg != '0) begin
                    rem_res_reg <= rem_res_reg - IDX_W'(1);
                end
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_seq_no     = out_seq_reg;
    assign m_frame_data = rd_data_reg;
    assign m_is_resend  = out_resend_reg;
    assign m_last       = out_last_reg;

endmodule

[sv/go_back_n_sender.sv]
// Top level of the go-back-n sender.
// Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
//
// Input channel (s_): one item per event. func load stores s_payload as
// the next frame (up to 32 frames); ack, timeout and start run the window.
// Result channel (m_): one item per transmitted frame, resends first,
// then new frames; m_last marks the final frame of an event.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 window_size,
// index 1 frame_count; write only while idle.
// Sequence: a load is stored and the sender stays ready. An ack/timeout/start
// event is accepted, then passes the planning step (slide and frame counts)
// and then emits its N frames (N <= 7);
// the next item is taken once the last frame is in the output register.
// Frames are read from a single-port frame store, one per cycle while out_free.
// Reset: window_size 5, frame_count 20, all pointers zero, output empty.
// The frame store is not cleared.
// When m_ready is low the output register holds its frame and emission
// pauses; no frame is dropped.
module go_back_n_sender
    import gbn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [DATA_W-1:0]    s_payload,
    input  logic [SEQ_W-1:0]     s_ack_seq,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SEQ_W-1:0]     m_seq_no,
    output logic [DATA_W-1:0]    m_frame_data,
    output logic                 m_is_resend,
    output logic                 m_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    gbn_cmd_t    cmd;
    gbn_status_t status;

    gbn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gbn_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_func       (s_func),
        .s_payload    (s_payload),
        .s_ack_seq    (s_ack_seq),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_seq_no     (m_seq_no),
        .m_frame_data (m_frame_data),
        .m_is_resend  (m_is_resend),
        .m_last       (m_last)
    );

endmodule

[sv/gbn_checker.sv]
// Port-level checks for the go-back-n sender, bound to the top level.
// Depends on gbn_pkg.
module gbn_checker
    import gbn_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [1:0]           s_func,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [SEQ_W-1:0]     m_seq_no,
    input logic [DATA_W-1:0]    m_frame_data,
    input logic                 m_is_resend,
    input logic                 m_last
);

    // stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_seq_no) &&
        $stable(m_frame_data) && $stable(m_is_resend) && $stable(m_last))
        else $error("output item changed while stalled");

    // an event blocks input until it is planned
    a_event_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func != FN_LOAD) |=> !s_ready)
        else $error("input accepted during event planning");

    // frames of one event come back to back when the sink takes them
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside an event's frames");

    // while idle only the final frame of an event can be pending
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_last)
        else $error("input ready while event still emitting");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);
